// ----- sv/swcd_pkg.sv -----
// swcd_pkg: shared types and constants of the sliding window critical detector
// no dependencies; imported by the interfaces, the evaluator, the top level, the checker and the bench
package swcd_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int HIGH_W     = $clog2(WINDOW_LEN + 1);
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [HIGH_W-1:0]          t_high;
    typedef logic [FILL_W-1:0]          t_fill;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef t_sample                    t_window [WINDOW_LEN];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_THR = 2'd0,
        CFG_MIN_HIGH  = 2'd1,
        CFG_CEILING   = 2'd2,
        CFG_AVG_THR   = 2'd3
    } t_cfg_idx;

    // avg_bound is the sum bound equivalent to a truncated mean compare
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level_thr;
        logic [HIGH_W-1:0]          min_high;
        logic signed [SAMPLE_W-1:0] ceiling;
        logic signed [SUM_W-1:0]    avg_bound;
    } t_cfg;

    localparam t_sample RST_LEVEL_THR = 16'sd70;
    localparam t_high   RST_MIN_HIGH  = 3'd3;
    localparam t_sample RST_CEILING   = 16'sd150;
    localparam t_sum    RST_AVG_BOUND = 19'sd450;
    localparam t_count  COUNT_MAX     = '1;

endpackage

// ----- sv/swcd_if.sv -----
// swcd_in_if and swcd_out_if: valid/ready channels carrying samples and results
// depends on swcd_pkg
interface swcd_in_if
    import swcd_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swcd_out_if
    import swcd_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   window_full;
    logic   critical;
    t_count critical_count;
    logic   sequence_end;

    modport source (output valid, output window_full, output critical,
                    output critical_count, output sequence_end, input ready);
    modport sink   (input valid, input window_full, input critical,
                    input critical_count, input sequence_end, output ready);
endinterface

// ----- sv/swcd_window_eval.sv -----
// swcd_window_eval: level, ceiling and mean criteria over one five-sample window
// depends on swcd_pkg
module swcd_window_eval
    import swcd_pkg::*;
(
    input  t_window i_win,
    input  t_cfg    i_cfg,
    output logic    o_critical
);

    t_high highs;
    logic  under;
    t_sum  sum;

    always_comb begin
        highs = '0;
        under = 1'b1;
        sum   = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (i_win[i] >= i_cfg.level_thr) begin
                highs = highs + t_high'(1);
            end
            if (i_win[i] > i_cfg.ceiling) begin
                under = 1'b0;
            end
            sum = sum + t_sum'(i_win[i]);
        end
    end

    assign o_critical = (highs >= i_cfg.min_high) && under && (sum >= i_cfg.avg_bound);

endmodule

// ----- sv/sliding_window_critical_detector_unit.sv -----
// sliding_window_critical_detector_unit: top level of the window detector
// a sample passes the window register and then the output register before its result is offered
// throughput: one sample per cycle while the output is not stalled; window shift and fill count
// update at transfer, criteria and tally evaluate from the window register into the output register
// reset: synchronous active low, clears fill level, tally, valids and config to defaults
// depends on swcd_pkg, swcd_if, swcd_window_eval
module sliding_window_critical_detector_unit
    import swcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    swcd_in_if.sink               i_in,
    swcd_out_if.source            o_res
);

    t_cfg    r_cfg;
    t_cfg    n_cfg;
    t_sample cfg_s;
    t_sum    avg_x5;

    t_window r_win;
    t_fill   r_fill;
    t_fill   n_fill;
    logic    r_s1_valid;
    logic    r_s1_full;
    logic    r_s1_last;

    logic    r_out_valid;
    logic    r_out_full;
    logic    r_out_crit;
    t_count  r_out_count;
    logic    r_out_last;
    t_count  r_tally;
    t_count  n_tally;

    logic    in_xfer;
    logic    out_free;
    logic    s1_adv;
    logic    eval_crit;
    logic    win_crit;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    // mean threshold folded into a bound on the sum
    assign cfg_s  = $signed(i_cfg_data);
    assign avg_x5 = (t_sum'(cfg_s) <<< 2) + t_sum'(cfg_s);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEVEL_THR: n_cfg.level_thr = cfg_s;
                CFG_MIN_HIGH:  n_cfg.min_high  = i_cfg_data[HIGH_W-1:0];
                CFG_CEILING:   n_cfg.ceiling   = cfg_s;
                CFG_AVG_THR:   n_cfg.avg_bound = (cfg_s > 0) ? avg_x5 : avg_x5 - t_sum'(4);
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_thr <= RST_LEVEL_THR;
            r_cfg.min_high  <= RST_MIN_HIGH;
            r_cfg.ceiling   <= RST_CEILING;
            r_cfg.avg_bound <= RST_AVG_BOUND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // window shift register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_LEN-1] <= i_in.sample;
            r_s1_last <= i_in.last_sample;
            r_s1_full <= (n_fill == t_fill'(WINDOW_LEN));
        end
    end

    assign n_fill = (r_fill < t_fill'(WINDOW_LEN)) ? r_fill + t_fill'(1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_fill     <= i_in.last_sample ? '0 : n_fill;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    swcd_window_eval u_eval (
        .i_win      (r_win),
        .i_cfg      (r_cfg),
        .o_critical (eval_crit)
    );

    assign win_crit = r_s1_full && eval_crit;
    assign n_tally  = (win_crit && (r_tally != COUNT_MAX)) ? r_tally + t_count'(1) : r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_tally     <= r_s1_last ? '0 : n_tally;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_full  <= r_s1_full;
            r_out_crit  <= win_crit;
            r_out_count <= n_tally;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.window_full    = r_out_full;
    assign o_res.critical       = r_out_crit;
    assign o_res.critical_count = r_out_count;
    assign o_res.sequence_end   = r_out_last;

endmodule

// ----- sv/swcd_checker.sv -----
// swcd_checker: port-level checks of the window detector, bound to the top level
// depends on swcd_pkg and sliding_window_critical_detector_unit
module swcd_checker
    import swcd_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_out_full,
    input logic   i_out_crit,
    input t_count i_out_count,
    input logic   i_out_last
);

    logic out_xfer;
    assign out_xfer = i_out_valid && i_out_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_count)
            && $stable(i_out_crit) && $stable(i_out_full) && $stable(i_out_last)))
        else $error("stalled result changed");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_crit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_crit) |-> i_out_full)
        else $error("critical without full window");

    // tally steps by the critical flag within a sequence
    a_tally_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !i_out_last) ##1 (out_xfer && $past(i_out_count) != COUNT_MAX)
            |-> (i_out_count == $past(i_out_count) + t_count'(i_out_crit)))
        else $error("tally step mismatch");

endmodule

bind sliding_window_critical_detector_unit swcd_checker u_swcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_full  (o_res.window_full),
    .i_out_crit  (o_res.critical),
    .i_out_count (o_res.critical_count),
    .i_out_last  (o_res.sequence_end)
);

// ----- tb/tb.sv -----
// tb: self-checking bench for sliding_window_critical_detector_unit
// drives samples and register writes, predicts each result or takes it from the plan, compares it on transfer
// depends on swcd_pkg, swcd_if and the unit under test
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swcd_pkg::*;

    typedef struct packed {
        logic   window_full;
        logic   critical;
        t_count critical_count;
        logic   sequence_end;
    } t_result;

    typedef struct packed {
        t_sample sample;
        logic    last;
        logic    typed;
        t_result exp;
    } t_plan_row;

    localparam int PLAN_LEN     = 21;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_SETTINGS = 8;
    localparam int DRAIN_LIMIT  = 2000;

    // directed rows, reset register values apply
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{16'sd100,   1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
        '{16'sd100,   1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
        '{16'sd100,   1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
        '{16'sd100,   1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
        '{16'sd100,   1'b0, 1'b1, '{1'b1, 1'b1, 16'd1, 1'b0}},
        '{16'sd150,   1'b0, 1'b1, '{1'b1, 1'b1, 16'd2, 1'b0}},
        '{16'sd151,   1'b0, 1'b1, '{1'b1, 1'b0, 16'd2, 1'b0}},
        '{16'sh7fff,  1'b0, 1'b1, '{1'b1, 1'b0, 16'd2, 1'b0}},
        '{16'sh8000,  1'b1, 1'b1, '{1'b1, 1'b0, 16'd2, 1'b1}},
        '{16'sd120,   1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
        '{16'sd120,   1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b1}},
        '{16'sd70,    1'b0, 1'b0, '0},
        '{16'sd69,    1'b0, 1'b0, '0},
        '{16'sd110,   1'b0, 1'b0, '0},
        '{16'sd110,   1'b0, 1'b0, '0},
        '{16'sd101,   1'b0, 1'b0, '0},
        '{16'sd69,    1'b0, 1'b0, '0},
        '{16'sd69,    1'b0, 1'b0, '0},
        '{16'sd60,    1'b0, 1'b0, '0},
        '{-16'sd1,    1'b0, 1'b0, '0},
        '{16'sh7fff,  1'b1, 1'b0, '0}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we  = 1'b0;
    t_cfg_idx              cfg_idx = CFG_LEVEL_THR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    swcd_in_if  in_ch ();
    swcd_out_if res_ch ();

    sliding_window_critical_detector_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_res      (res_ch.source)
    );

    // predicted detector state and register copy
    t_sample     window_hist [WINDOW_LEN];
    int          fill_level;
    int          tally;
    t_sample     lvl_thr;
    logic [2:0]  min_high;
    t_sample     ceil_lvl;
    t_sample     avg_thr;

    t_result     expected_results [$];
    logic        row_typed = 1'b0;
    t_result     row_exp   = '0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          errors = 0;
    int          n_samples = 0;
    int          n_windows = 0;
    int          n_critical = 0;
    int          n_sequences = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_detector();
        foreach (window_hist[i]) window_hist[i] = '0;
        fill_level = 0;
        tally      = 0;
        lvl_thr    = RST_LEVEL_THR;
        min_high   = RST_MIN_HIGH;
        ceil_lvl   = RST_CEILING;
        avg_thr    = t_sample'(RST_AVG_BOUND / WINDOW_LEN);
    endfunction

    function automatic t_result step_window(t_sample s, logic last);
        t_result r;
        int      highs;
        int      sum;
        logic    under;
        for (int i = 0; i < WINDOW_LEN - 1; i++) window_hist[i] = window_hist[i + 1];
        window_hist[WINDOW_LEN - 1] = s;
        if (fill_level < WINDOW_LEN) fill_level++;
        r = '0;
        r.sequence_end = last;
        if (fill_level == WINDOW_LEN) begin
            r.window_full = 1'b1;
            highs = 0;
            sum   = 0;
            under = 1'b1;
            foreach (window_hist[i]) begin
                if (window_hist[i] >= lvl_thr) highs++;
                if (window_hist[i] > ceil_lvl) under = 1'b0;
                sum += int'(window_hist[i]);
            end
            // int division truncates toward zero
            if (highs >= int'(min_high) && under && sum / WINDOW_LEN >= int'(avg_thr)) begin
                r.critical = 1'b1;
                if (tally < int'(COUNT_MAX)) tally++;
            end
        end
        r.critical_count = t_count'(tally);
        if (last) begin
            fill_level = 0;
            tally      = 0;
        end
        return r;
    endfunction

    task automatic check_result(input t_result want, input t_result got);
        if (got.window_full !== want.window_full) begin
            $error("window_full: expected %0d, got %0d", want.window_full, got.window_full);
            errors++;
        end
        if (got.critical !== want.critical) begin
            $error("critical: expected %0d, got %0d", want.critical, got.critical);
            errors++;
        end
        if (got.critical_count !== want.critical_count) begin
            $error("critical_count: expected %0d, got %0d",
                   want.critical_count, got.critical_count);
            errors++;
        end
        if (got.sequence_end !== want.sequence_end) begin
            $error("sequence_end: expected %0d, got %0d", want.sequence_end, got.sequence_end);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result pred;
        if (!i_rst_n) begin
            clear_detector();
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_LEVEL_THR: lvl_thr  = t_sample'(cfg_data);
                    CFG_MIN_HIGH:  min_high = cfg_data[2:0];
                    CFG_CEILING:   ceil_lvl = t_sample'(cfg_data);
                    CFG_AVG_THR:   avg_thr  = t_sample'(cfg_data);
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.window_full, res_ch.critical,
                        res_ch.critical_count, res_ch.sequence_end};
                if (expected_results.size() == 0) begin
                    $error("result transfer with no sample pending");
                    errors++;
                end else begin
                    check_result(expected_results.pop_front(), got);
                end
                if (got.window_full) n_windows++;
                if (got.critical) n_critical++;
                if (got.sequence_end) n_sequences++;
            end
            if (in_ch.valid && in_ch.ready) begin
                pred = step_window(in_ch.sample, in_ch.last_sample);
                expected_results.push_back(row_typed ? row_exp : pred);
                n_samples++;
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready = (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // called right after a falling edge, returns right after one
    task automatic put_sample(input t_sample s, input logic last,
                              input logic typed, input t_result want);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.sample      = s;
        in_ch.last_sample = last;
        row_typed         = typed;
        row_exp           = want;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid = 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = d;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    function automatic t_sample clip(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_sample'(v);
    endfunction

    task automatic load_setting(input int p);
        int base;
        base = int'(t_sample'($urandom));
        case (p)
            0: begin
                write_reg(CFG_LEVEL_THR, 16'd70);
                write_reg(CFG_MIN_HIGH,  16'd3);
                write_reg(CFG_CEILING,   16'd150);
                write_reg(CFG_AVG_THR,   16'd90);
            end
            1: begin
                write_reg(CFG_LEVEL_THR, 16'h8000);
                write_reg(CFG_MIN_HIGH,  16'd0);
                write_reg(CFG_CEILING,   16'h8000);
                write_reg(CFG_AVG_THR,   16'h8000);
            end
            2: begin
                write_reg(CFG_LEVEL_THR, 16'h7fff);
                write_reg(CFG_MIN_HIGH,  16'd5);
                write_reg(CFG_CEILING,   16'h7fff);
                write_reg(CFG_AVG_THR,   16'h7fff);
            end
            3: begin
                // upper data bits set, only the low three land in the register
                write_reg(CFG_LEVEL_THR, 16'd100);
                write_reg(CFG_MIN_HIGH,  16'hfff6);
                write_reg(CFG_CEILING,   16'd300);
                write_reg(CFG_AVG_THR,   16'd50);
            end
            4: begin
                write_reg(CFG_LEVEL_THR, -16'sd200);
                write_reg(CFG_MIN_HIGH,  16'd7);
                write_reg(CFG_CEILING,   16'd1000);
                write_reg(CFG_AVG_THR,   -16'sd1000);
            end
            5: begin
                write_reg(CFG_LEVEL_THR, clip(base));
                write_reg(CFG_MIN_HIGH,  16'($urandom_range(5)));
                write_reg(CFG_CEILING,   clip(base + int'($urandom_range(2000))));
                write_reg(CFG_AVG_THR,   clip(base + int'($urandom_range(400)) - 200));
            end
            6: begin
                write_reg(CFG_LEVEL_THR, -16'sd100);
                write_reg(CFG_MIN_HIGH,  16'd2);
                write_reg(CFG_CEILING,   16'd50);
                write_reg(CFG_AVG_THR,   -16'sd20);
            end
            7: begin
                write_reg(CFG_LEVEL_THR, -16'sd10);
                write_reg(CFG_MIN_HIGH,  16'd0);
                write_reg(CFG_CEILING,   16'd10);
                write_reg(CFG_AVG_THR,   16'd0);
            end
            default: begin
                // every full window critical
                write_reg(CFG_LEVEL_THR, 16'h8000);
                write_reg(CFG_MIN_HIGH,  16'd0);
                write_reg(CFG_CEILING,   16'h7fff);
                write_reg(CFG_AVG_THR,   16'h8000);
            end
        endcase
    endtask

    function automatic t_sample pick_sample(bit biased, int lo, int hi);
        if (biased && $urandom_range(99) < 85) return clip(lo + int'($urandom_range(hi - lo)));
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic run_sequences(input int n_items, input bit hold_midway);
        int done;
        int len;
        int lo;
        int hi;
        bit biased;
        bit held;
        done = 0;
        held = 1'b0;
        while (done < n_items) begin
            len    = ($urandom_range(99) < 80) ? $urandom_range(24, 5) : $urandom_range(4, 1);
            biased = $urandom_range(99) < 70;
            lo     = ((lvl_thr < avg_thr) ? int'(lvl_thr) : int'(avg_thr)) - 4;
            hi     = int'(ceil_lvl) + 2;
            if (lo > hi) lo = hi - 8;
            for (int j = 0; j < len; j++) begin
                put_sample(pick_sample(biased, lo, hi), j == len - 1, 1'b0, '0);
            end
            done += len;
            if (hold_midway && !held && done >= n_items / 2) begin
                held = 1'b1;
                drain();
            end
        end
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        res_ch.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < PLAN_LEN; k++) begin
            put_sample(PLAN[k].sample, PLAN[k].last, PLAN[k].typed, PLAN[k].exp);
        end
        drain();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            load_setting(p);
            tx_idle_pct  = (p % 4 == 1) ? 86 : (p % 4 == 3) ? 34 : 0;
            rx_stall_pct = (p % 4 == 2) ? 86 : (p % 4 == 3) ? 34 : 0;
            run_sequences(PHASE_ITEMS, p == 2);
            drain();
        end

        $display("run covered %0d sample transfers, %0d sequence ends, %0d full windows, %0d critical",
                 n_samples, n_sequences, n_windows, n_critical);
        $display("eight register settings, four handshake patterns, short and long sequences");
        if (errors == 0) begin
            $display("PASS sliding_window_critical_detector_unit");
        end else begin
            $display("FAIL sliding_window_critical_detector_unit");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL sliding_window_critical_detector_unit");
        $finish;
    end

endmodule

// ----- files.f -----
sv/swcd_pkg.sv
sv/swcd_if.sv
sv/swcd_window_eval.sv
sv/sliding_window_critical_detector_unit.sv
sv/swcd_checker.sv
tb/tb.sv
